/* hw/rtl/igbh_pkg.sv */
// ----------------------------------------------------------------------------
// igbh_pkg
// Shared widths, register indexes, divider request types and saturation
// helpers for the gyro bias and heading block.
// ----------------------------------------------------------------------------
package igbh_pkg;

  localparam int GYRO_W  = 32;
  localparam int ACC_W   = 16;
  localparam int SCALE_W = 24;
  localparam int RATE_W  = 32;
  localparam int ANGLE_W = 48;
  localparam int CNT_W   = 16;
  localparam int PROD_W  = 58;
  localparam int DIV_W   = 58;
  localparam int AX_W    = 2;
  localparam int STILL_W = 5;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_GYRO_GAIN  = 2'd0;
  localparam logic [IDX_W-1:0] REG_ACCEL_GAIN = 2'd1;
  localparam logic [IDX_W-1:0] REG_FRAME_DT   = 2'd2;

  localparam logic [SCALE_W-1:0] GYRO_GAIN_RST  = 24'd4000;
  localparam logic [SCALE_W-1:0] ACCEL_GAIN_RST = 24'd156700;
  localparam logic [SCALE_W-1:0] FRAME_DT_RST   = 24'd20140;

  localparam logic [STILL_W-1:0] STILL_MAX    = 5'd31;
  localparam logic [STILL_W-1:0] WEIGHT_LIMIT = 5'd20;

  localparam logic OP_FRAME = 1'b0;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic signed [RATE_W-1:0] sat32(input logic signed [59:0] v);
    if (v > 60'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -60'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[RATE_W-1:0];
  endfunction

  function automatic logic signed [ANGLE_W-1:0] sat48(input logic signed [49:0] v);
    if (v > 50'sd140737488355327) begin
      return 48'sh7FFFFFFFFFFF;
    end else if (v < -50'sd140737488355328) begin
      return 48'sh800000000000;
    end
    return v[ANGLE_W-1:0];
  endfunction

endpackage

/* hw/rtl/igbh_div.sv */
// ----------------------------------------------------------------------------
// igbh_div
// Bit-serial restoring divider on unsigned magnitudes, one quotient bit per
// cycle.
// ----------------------------------------------------------------------------
module igbh_div (
  input  logic              clk,
  input  logic              rst_n,
  input  igbh_pkg::div_req_t req,
  output igbh_pkg::div_rsp_t rsp
);
  import igbh_pkg::*;

  localparam int ITER_W = $clog2(DIV_W);
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(DIV_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] iter_r;
  logic [DIV_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  div_r;
  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [CNT_W:0]    rem_sub;

  assign rem_sh  = {rem_r, quo_r[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, div_r};
  assign rem_sub = rem_sh - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
      end else if (busy_r) begin
        iter_r <= iter_r + 1'b1;
        if (iter_r == LAST_ITER) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      div_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> req.divisor != '0) else $error("divide by zero");
`endif

endmodule

/* hw/rtl/imu_gyro_bias_and_heading.sv */
// ----------------------------------------------------------------------------
// imu_gyro_bias_and_heading
// Gyro bias estimation from stationary summaries and heading integration
// from raw IMU frames, on one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
// A raw frame is worked axis by axis on the single shared 33x25 multiplier.
// A stationary summary with a nonzero count is worked axis by axis on the
// bit-serial divider, which produces 58 quotient bits and then reports, once
// for the mean and once for the blend weight of each axis. A summary with a
// zero count goes straight to the result. One item is in work at a time; the
// finished result sits in an output register, so the next item is taken while
// it waits.
module imu_gyro_bias_and_heading #(
  parameter int AXES = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_operation,
  input  logic signed [igbh_pkg::GYRO_W-1:0]   in_gyro_x,
  input  logic signed [igbh_pkg::GYRO_W-1:0]   in_gyro_y,
  input  logic signed [igbh_pkg::GYRO_W-1:0]   in_gyro_z,
  input  logic signed [igbh_pkg::ACC_W-1:0]    in_accel_x,
  input  logic signed [igbh_pkg::ACC_W-1:0]    in_accel_y,
  input  logic signed [igbh_pkg::ACC_W-1:0]    in_accel_z,
  input  logic [igbh_pkg::CNT_W-1:0]           in_sample_count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [igbh_pkg::RATE_W-1:0]   out_rate_x,
  output logic signed [igbh_pkg::RATE_W-1:0]   out_rate_y,
  output logic signed [igbh_pkg::RATE_W-1:0]   out_rate_z,
  output logic signed [igbh_pkg::RATE_W-1:0]   out_accel_out_x,
  output logic signed [igbh_pkg::RATE_W-1:0]   out_accel_out_y,
  output logic signed [igbh_pkg::RATE_W-1:0]   out_accel_out_z,
  output logic signed [igbh_pkg::ANGLE_W-1:0]  out_angle_x,
  output logic signed [igbh_pkg::ANGLE_W-1:0]  out_angle_y,
  output logic signed [igbh_pkg::ANGLE_W-1:0]  out_angle_z,
  input  logic                                 cfg_wr_en,
  input  logic [igbh_pkg::IDX_W-1:0]           cfg_index,
  input  logic [igbh_pkg::SCALE_W-1:0]         cfg_wdata
);
  import igbh_pkg::*;

  localparam logic [AX_W-1:0] LAST_AX = AX_W'(AXES - 1);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_STILL = 12'b000000000010,
    ST_MUL_G = 12'b000000000100,
    ST_RATE  = 12'b000000001000,
    ST_MUL_T = 12'b000000010000,
    ST_ANGLE = 12'b000000100000,
    ST_ACCEL = 12'b000001000000,
    ST_GO1   = 12'b000010000000,
    ST_WAIT1 = 12'b000100000000,
    ST_GO2   = 12'b001000000000,
    ST_WAIT2 = 12'b010000000000,
    ST_DONE  = 12'b100000000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic [SCALE_W-1:0] gyro_gain_r;
  logic [SCALE_W-1:0] accel_gain_r;
  logic [SCALE_W-1:0] frame_dt_r;

  logic                     op_r;
  logic signed [GYRO_W-1:0] gyro_r  [3];
  logic signed [ACC_W-1:0]  accel_r [3];
  logic [CNT_W-1:0]         n_r;

  logic signed [RATE_W-1:0]  bias_r      [3];
  logic signed [ANGLE_W-1:0] angle_r     [3];
  logic signed [RATE_W-1:0]  rate_r      [3];
  logic signed [RATE_W-1:0]  acc_r       [3];
  logic [STILL_W-1:0]        still_r;
  logic [STILL_W-1:0]        still_nxt;
  logic [STILL_W-1:0]        d_r;

  logic [AX_W-1:0]          ax_r;
  logic signed [32:0]       mul_a;
  logic signed [24:0]       mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] diff_r;
  logic signed [PROD_W-1:0] mean;
  logic signed [59:0]       qs;
  logic                     neg_r;
  logic signed [49:0]       step;

  logic signed [RATE_W-1:0]  out_rate_r  [3];
  logic signed [RATE_W-1:0]  out_acc_r   [3];
  logic signed [ANGLE_W-1:0] out_angle_r [3];
  logic                      out_valid_r;
  logic                      load_out;

  div_req_t div_req;
  div_rsp_t div_rsp;

  igbh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign still_nxt = (still_r == STILL_MAX) ? STILL_MAX : still_r + 1'b1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL_G: begin
        mul_a = 33'(gyro_r[ax_r]);
        mul_b = {1'b0, gyro_gain_r};
      end
      ST_MUL_T: begin
        mul_a = 33'(rate_r[ax_r]);
        mul_b = {1'b0, frame_dt_r};
      end
      ST_ANGLE: begin
        mul_a = 33'(accel_r[ax_r]);
        mul_b = {1'b0, accel_gain_r};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign step = 50'(prod_r >>> 24);
  assign mean = neg_r ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient);
  assign qs   = neg_r ? -$signed({2'b00, div_rsp.quotient})
                      : $signed({2'b00, div_rsp.quotient});

  always_comb begin
    div_req.start    = (state_r == ST_GO1) || (state_r == ST_GO2);
    div_req.divisor  = n_r;
    div_req.dividend = prod_r[PROD_W-1] ? -prod_r : prod_r;
    if (state_r == ST_GO2) begin
      div_req.divisor  = {{(CNT_W-STILL_W){1'b0}}, d_r};
      div_req.dividend = diff_r[PROD_W-1] ? -diff_r : diff_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_FRAME) begin
            state_nxt = ST_MUL_G;
          end else if (in_sample_count != '0) begin
            state_nxt = ST_STILL;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_STILL: state_nxt = ST_MUL_G;
      ST_MUL_G: state_nxt = (op_r == OP_FRAME) ? ST_RATE : ST_GO1;
      ST_RATE:  state_nxt = ST_MUL_T;
      ST_MUL_T: state_nxt = ST_ANGLE;
      ST_ANGLE: state_nxt = ST_ACCEL;
      ST_ACCEL: state_nxt = (ax_r == LAST_AX) ? ST_DONE : ST_MUL_G;
      ST_GO1:   state_nxt = ST_WAIT1;
      ST_WAIT1: begin
        if (div_rsp.done) begin
          state_nxt = ST_GO2;
        end
      end
      ST_GO2:   state_nxt = ST_WAIT2;
      ST_WAIT2: begin
        if (div_rsp.done) begin
          state_nxt = (ax_r == LAST_AX) ? ST_DONE : ST_MUL_G;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      gyro_gain_r  <= GYRO_GAIN_RST;
      accel_gain_r <= ACCEL_GAIN_RST;
      frame_dt_r   <= FRAME_DT_RST;
      still_r      <= '0;
      ax_r         <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        bias_r[i]  <= '0;
        angle_r[i] <= '0;
        rate_r[i]  <= '0;
        acc_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_GYRO_GAIN:  gyro_gain_r  <= cfg_wdata;
          REG_ACCEL_GAIN: accel_gain_r <= cfg_wdata;
          REG_FRAME_DT:   frame_dt_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        ax_r <= '0;
      end
      if (state_r == ST_STILL) begin
        still_r <= still_nxt;
      end
      if (state_r == ST_RATE) begin
        rate_r[ax_r] <= sat32(60'(prod_r) - 60'(bias_r[ax_r]));
      end
      if (state_r == ST_ANGLE) begin
        angle_r[ax_r] <= sat48(50'(angle_r[ax_r]) + step);
      end
      if (state_r == ST_ACCEL) begin
        acc_r[ax_r] <= sat32(60'(prod_r));
        ax_r <= ax_r + 1'b1;
      end
      if ((state_r == ST_WAIT2) && div_rsp.done) begin
        bias_r[ax_r] <= sat32(60'(bias_r[ax_r]) + qs);
        ax_r <= ax_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r       <= in_operation;
      n_r        <= in_sample_count;
      gyro_r[0]  <= in_gyro_x;
      gyro_r[1]  <= in_gyro_y;
      gyro_r[2]  <= in_gyro_z;
      accel_r[0] <= in_accel_x;
      accel_r[1] <= in_accel_y;
      accel_r[2] <= in_accel_z;
    end
    if (state_r == ST_STILL) begin
      d_r <= (still_nxt < WEIGHT_LIMIT) ? still_nxt : WEIGHT_LIMIT;
    end
    if ((state_r == ST_MUL_G) || (state_r == ST_MUL_T) || (state_r == ST_ANGLE)) begin
      prod_r <= prod;
    end
    if (state_r == ST_GO1) begin
      neg_r <= prod_r[PROD_W-1];
    end
    if (state_r == ST_GO2) begin
      neg_r <= diff_r[PROD_W-1];
    end
    if ((state_r == ST_WAIT1) && div_rsp.done) begin
      diff_r <= mean - PROD_W'(bias_r[ax_r]);
    end
    if (load_out) begin
      for (int i = 0; i < 3; i++) begin
        out_rate_r[i]  <= rate_r[i];
        out_acc_r[i]   <= acc_r[i];
        out_angle_r[i] <= angle_r[i];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rate_x      = out_rate_r[0];
  assign out_rate_y      = out_rate_r[1];
  assign out_rate_z      = out_rate_r[2];
  assign out_accel_out_x = out_acc_r[0];
  assign out_accel_out_y = out_acc_r[1];
  assign out_accel_out_z = out_acc_r[2];
  assign out_angle_x     = out_angle_r[0];
  assign out_angle_y     = out_angle_r[1];
  assign out_angle_z     = out_angle_r[2];

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state register not one-hot");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rate_x)
      && $stable(out_accel_out_y) && $stable(out_angle_z))
    else $error("result changed while waiting");
  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GO2) |-> (d_r != '0) && (d_r <= WEIGHT_LIMIT))
    else $error("blend weight out of range");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the gyro bias and heading block. Raw frames and
// stationary summaries go in under several gain and frame-period settings,
// with random gaps, random output stalls and one long output hold-off.
// Every result is compared field by field with an in-bench model.
// ----------------------------------------------------------------------------
module tb;
  import igbh_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic OP_SUMMARY = 1'b1;
  localparam logic [SCALE_W-1:0] SCALE_MAX = '1;

  typedef struct {
    logic        op;
    int          gyro[3];
    shortint     acc[3];
    logic [15:0] cnt;
  } imu_item_t;

  typedef struct {
    int     rate[3];
    int     acc[3];
    longint ang[3];
  } imu_result_t;

  class heading_scoreboard;
    longint      gyro_gain, accel_gain, frame_dt;
    longint      bias[3], heading[3], rate_now[3], acc_now[3];
    int          still;
    imu_result_t pending_q[$];
    int          errors, frames, summaries, results;

    function new();
      gyro_gain  = GYRO_GAIN_RST;
      accel_gain = ACCEL_GAIN_RST;
      frame_dt   = FRAME_DT_RST;
      still = 0;
      errors = 0; frames = 0; summaries = 0; results = 0;
      for (int i = 0; i < 3; i++) begin
        bias[i] = 0; heading[i] = 0; rate_now[i] = 0; acc_now[i] = 0;
      end
    endfunction

    function longint clamp(longint v, int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [SCALE_W-1:0] val);
      case (idx)
        REG_GYRO_GAIN:  gyro_gain  = val;
        REG_ACCEL_GAIN: accel_gain = val;
        REG_FRAME_DT:   frame_dt   = val;
        default: ;
      endcase
    endfunction

    function void note_item(imu_item_t it);
      imu_result_t r;
      longint d;
      longint avg;
      if (it.op == OP_FRAME) begin
        frames++;
        for (int i = 0; i < 3; i++) begin
          rate_now[i] = clamp(longint'(it.gyro[i]) * gyro_gain - bias[i], 32);
          acc_now[i]  = clamp(longint'(it.acc[i]) * accel_gain, 32);
          heading[i]  = clamp(heading[i] + ((rate_now[i] * frame_dt) >>> 24), 48);
        end
      end else if (it.cnt != 0) begin
        summaries++;
        if (still < STILL_MAX) still++;
        d = (still < WEIGHT_LIMIT) ? still : WEIGHT_LIMIT;
        for (int i = 0; i < 3; i++) begin
          avg = (longint'(it.gyro[i]) * gyro_gain) / longint'({48'd0, it.cnt});
          bias[i] = clamp(bias[i] + (avg - bias[i]) / d, 32);
        end
      end
      for (int i = 0; i < 3; i++) begin
        r.rate[i] = int'(rate_now[i]);
        r.acc[i]  = int'(acc_now[i]);
        r.ang[i]  = heading[i];
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(imu_result_t got);
      imu_result_t exp_r;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding", $time);
        return;
      end
      exp_r = pending_q.pop_front();
      results++;
      for (int i = 0; i < 3; i++) begin
        if (got.rate[i] !== exp_r.rate[i]) begin
          errors++;
          $display("%0t: rate[%0d] exp %0d got %0d", $time, i, exp_r.rate[i], got.rate[i]);
        end
        if (got.acc[i] !== exp_r.acc[i]) begin
          errors++;
          $display("%0t: accel[%0d] exp %0d got %0d", $time, i, exp_r.acc[i], got.acc[i]);
        end
        if (got.ang[i] !== exp_r.ang[i]) begin
          errors++;
          $display("%0t: angle[%0d] exp %0d got %0d", $time, i, exp_r.ang[i], got.ang[i]);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = 1'b0;
  logic signed [GYRO_W-1:0] in_gyro_x = '0, in_gyro_y = '0, in_gyro_z = '0;
  logic signed [ACC_W-1:0] in_accel_x = '0, in_accel_y = '0, in_accel_z = '0;
  logic [CNT_W-1:0] in_sample_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [RATE_W-1:0] out_rate_x, out_rate_y, out_rate_z;
  logic signed [RATE_W-1:0] out_accel_out_x, out_accel_out_y, out_accel_out_z;
  logic signed [ANGLE_W-1:0] out_angle_x, out_angle_y, out_angle_z;
  logic cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [SCALE_W-1:0] cfg_wdata = '0;

  heading_scoreboard sb = new();
  bit gaps_on = 1'b1;
  int hold_req = 0;

  imu_gyro_bias_and_heading dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int burst;
    int hold;
    burst = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ready = 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ready = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 2);
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    imu_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.rate = '{out_rate_x, out_rate_y, out_rate_z};
      got.acc  = '{out_accel_out_x, out_accel_out_y, out_accel_out_z};
      got.ang  = '{longint'(out_angle_x), longint'(out_angle_y), longint'(out_angle_z)};
      sb.check_result(got);
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [SCALE_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_item(imu_item_t it);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_operation = it.op;
    {in_gyro_x, in_gyro_y, in_gyro_z} = {it.gyro[0], it.gyro[1], it.gyro[2]};
    {in_accel_x, in_accel_y, in_accel_z} = {it.acc[0], it.acc[1], it.acc[2]};
    in_sample_count = it.cnt;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic imu_item_t make_item(logic op, int g, shortint a, logic [15:0] n);
    imu_item_t it;
    it.op = op;
    it.gyro = '{g, -g, g >>> 3};
    it.acc = '{a, -a, a >>> 2};
    it.cnt = n;
    return it;
  endfunction

  function automatic imu_item_t rand_item();
    imu_item_t it;
    it.op = ($urandom_range(0, 9) == 0) ? OP_SUMMARY : OP_FRAME;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 3))
        0: it.gyro[i] = $urandom;
        1: it.gyro[i] = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
        default: it.gyro[i] = int'($urandom_range(0, 60000)) - 30000;
      endcase
      it.acc[i] = ACC_W'($urandom);
    end
    case ($urandom_range(0, 9))
      0: it.cnt = '0;
      1: it.cnt = 16'hFFFF;
      2, 3: it.cnt = CNT_W'($urandom);
      default: it.cnt = CNT_W'($urandom_range(1, 200));
    endcase
    return it;
  endfunction

  task automatic random_run(int n);
    for (int k = 0; k < n; k++) send_item(rand_item());
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_item(make_item(OP_FRAME, 0, '0, '0));
    send_item(make_item(OP_FRAME, 32'h7FFFFFFF, 16'sh7FFF, '0));
    send_item(make_item(OP_FRAME, 32'h80000000, 16'sh8000, 16'hFFFF));
    send_item(make_item(OP_FRAME, 1000, -16'sd1000, '0));
    send_item(make_item(OP_SUMMARY, 50000, '0, '0));
    send_item(make_item(OP_SUMMARY, 50000, '0, 16'd1));
    send_item(make_item(OP_SUMMARY, 32'h7FFFFFFF, '0, 16'd1));
    send_item(make_item(OP_SUMMARY, 32'h80000000, '0, 16'hFFFF));
    send_item(make_item(OP_FRAME, -1, 16'sd1, '0));
    for (int k = 0; k < 12; k++) begin
      send_item(make_item(OP_SUMMARY, 7000 * k - 40000, '0, 16'(k + 1)));
    end
    send_item(make_item(OP_FRAME, 123, 16'sd45, '0));
    drain();

    write_reg(REG_UNUSED, SCALE_MAX);
    write_reg(REG_GYRO_GAIN, SCALE_W'($urandom));
    write_reg(REG_ACCEL_GAIN, SCALE_W'($urandom));
    write_reg(REG_FRAME_DT, SCALE_W'($urandom));
    random_run(280);
    drain();

    write_reg(REG_GYRO_GAIN, SCALE_MAX);
    write_reg(REG_ACCEL_GAIN, SCALE_MAX);
    write_reg(REG_FRAME_DT, SCALE_MAX);
    random_run(150);
    drain();

    write_reg(REG_GYRO_GAIN, '0);
    write_reg(REG_ACCEL_GAIN, '0);
    write_reg(REG_FRAME_DT, '0);
    random_run(80);
    drain();

    write_reg(REG_GYRO_GAIN, SCALE_W'($urandom_range(1, 20000)));
    write_reg(REG_ACCEL_GAIN, SCALE_W'($urandom_range(1, 300000)));
    write_reg(REG_FRAME_DT, SCALE_W'($urandom_range(1, 100000)));
    hold_req = 300;
    random_run(200);
    drain();

    gaps_on = 1'b0;
    write_reg(REG_GYRO_GAIN, GYRO_GAIN_RST);
    write_reg(REG_ACCEL_GAIN, ACCEL_GAIN_RST);
    write_reg(REG_FRAME_DT, FRAME_DT_RST);
    random_run(170);
    drain();

    $display("Covered %0d frames and %0d nonzero summaries over five settings;",
             sb.frames, sb.summaries);
    $display("%0d results checked.", sb.results);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
hw/rtl/igbh_pkg.sv
hw/rtl/igbh_div.sv
hw/rtl/imu_gyro_bias_and_heading.sv
test/tb.sv
